/* hw/rtl/lqci_pkg.sv */
`default_nettype none

package lqci_pkg;

	localparam int CFG_DATA_W = 24;
	localparam int CFG_ADDR_W = 2;
	localparam int LEVEL_W    = 4;
	localparam int INDEX_W    = 15;
	localparam int NUM_COORDS = 4;

	typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

	localparam cfg_addr_t REG_TREE_LEVELS = 2'd0;
	localparam cfg_addr_t REG_CELL_WIDTH  = 2'd1;
	localparam cfg_addr_t REG_CELL_HEIGHT = 2'd2;

	localparam logic [LEVEL_W-1:0]    LEVELS_RESET    = 4'd8;
	localparam logic [CFG_DATA_W-1:0] CELL_SIZE_RESET = 24'd256;

	typedef struct packed {
		logic valid;
		logic outside;
	} beat_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/linear_quadtree_cell_index.sv */
// Linear quadtree cell index of a box. A box is taken on every cycle that start is high;
// busy stays low, so boxes may follow back to back. Each box's result appears on a
// single-cycle done strobe, and the receiver cannot stall it. Each box passes through
// an entry stage (grid bound check), a chain of MAX_DEPTH divider cells, each resolving
// one quotient bit of all four corner coordinates, and an index stage (Morton code, shared
// level, offset). The user must write registers through wr_en/wr_index/wr_data only while
// no box is in flight; the block itself does not enforce this.
`default_nettype none

module linear_quadtree_cell_index #(
	parameter int MAX_DEPTH  = 8,
	parameter int COORD_BITS = 24
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire  [COORD_BITS-1:0]            left_x,
	input  wire  [COORD_BITS-1:0]            low_y,
	input  wire  [COORD_BITS-1:0]            right_x,
	input  wire  [COORD_BITS-1:0]            high_y,
	output logic                             done,
	output logic                             valid_res,
	output logic [lqci_pkg::INDEX_W-1:0]     cell_index,
	output logic [lqci_pkg::LEVEL_W-1:0]     cell_depth,
	input  wire                              wr_en,
	input  lqci_pkg::cfg_addr_t              wr_index,
	input  wire  [lqci_pkg::CFG_DATA_W-1:0]  wr_data
);

	import lqci_pkg::*;

	localparam int W      = COORD_BITS + MAX_DEPTH;
	localparam int WIDE_W = CFG_DATA_W + COORD_BITS;
	localparam logic [WIDE_W-1:0] SIZE_RST_WIDE = WIDE_W'(CELL_SIZE_RESET);
	localparam logic [LEVEL_W-1:0] MAX_LV = LEVEL_W'(MAX_DEPTH);

	logic [LEVEL_W-1:0]    tree_levels_q;
	logic [COORD_BITS-1:0] cell_width_q;
	logic [COORD_BITS-1:0] cell_height_q;
	logic [WIDE_W-1:0]     wr_wide;
	logic [LEVEL_W-1:0]    lv;

	logic [NUM_COORDS-1:0][COORD_BITS-1:0] pos;
	logic [W-1:0]                          bound [NUM_COORDS];
	logic                                  outside;

	beat_ctl_t                              ctl_c [MAX_DEPTH+1];
	logic [NUM_COORDS-1:0][COORD_BITS-1:0]  rem_c [MAX_DEPTH+1];
	logic [NUM_COORDS-1:0][MAX_DEPTH-1:0]   quo_c [MAX_DEPTH+1];

	beat_ctl_t                              ctl_s1;
	logic [NUM_COORDS-1:0][COORD_BITS-1:0]  pos_s1;

	// configuration registers
	assign wr_wide = {{COORD_BITS{1'b0}}, wr_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tree_levels_q <= LEVELS_RESET;
			cell_width_q  <= SIZE_RST_WIDE[COORD_BITS-1:0];
			cell_height_q <= SIZE_RST_WIDE[COORD_BITS-1:0];
		end else if (wr_en) begin
			case (wr_index)
				REG_TREE_LEVELS: tree_levels_q <= wr_data[LEVEL_W-1:0];
				REG_CELL_WIDTH:  cell_width_q  <= wr_wide[COORD_BITS-1:0];
				REG_CELL_HEIGHT: cell_height_q <= wr_wide[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign lv   = (tree_levels_q > MAX_LV) ? MAX_LV : tree_levels_q;
	assign busy = 1'b0;

	// entry stage: grid bound check, q >= 2^lv exactly when p >= size << lv
	assign pos = {high_y, right_x, low_y, left_x};

	always_comb begin
		outside = 1'b0;
		for (int j = 0; j < NUM_COORDS; j++) begin
			if (j % 2 == 0) begin
				bound[j] = {{MAX_DEPTH{1'b0}}, cell_width_q} << lv;
			end else begin
				bound[j] = {{MAX_DEPTH{1'b0}}, cell_height_q} << lv;
			end
			if ({{MAX_DEPTH{1'b0}}, pos[j]} >= bound[j]) begin
				outside = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid   <= start && !busy;
			ctl_s1.outside <= outside;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= pos;
	end

	assign ctl_c[0] = ctl_s1;
	assign rem_c[0] = pos_s1;
	assign quo_c[0] = '0;

	// divider chain, most significant quotient bit first
	for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
		lqci_div_cell #(
			.COORD_BITS(COORD_BITS),
			.MAX_DEPTH (MAX_DEPTH),
			.STEP      (MAX_DEPTH - 1 - g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.size_x (cell_width_q),
			.size_y (cell_height_q),
			.ctl_in (ctl_c[g]),
			.rem_in (rem_c[g]),
			.quo_in (quo_c[g]),
			.ctl_out(ctl_c[g+1]),
			.rem_out(rem_c[g+1]),
			.quo_out(quo_c[g+1])
		);
	end

	lqci_index #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_index (
		.clk       (clk),
		.arst_n    (arst_n),
		.lv        (lv),
		.ctl_in    (ctl_c[MAX_DEPTH]),
		.quo_in    (quo_c[MAX_DEPTH]),
		.done      (done),
		.valid_res (valid_res),
		.cell_index(cell_index),
		.cell_depth(cell_depth)
	);

endmodule

`default_nettype wire

/* hw/rtl/lqci_div_cell.sv */
`default_nettype none

module lqci_div_cell #(
	parameter int COORD_BITS = 24,
	parameter int MAX_DEPTH  = 8,
	parameter int STEP       = 0
) (
	input  wire                                             clk,
	input  wire                                             arst_n,
	input  wire  [COORD_BITS-1:0]                           size_x,
	input  wire  [COORD_BITS-1:0]                           size_y,
	input  lqci_pkg::beat_ctl_t                             ctl_in,
	input  wire  [lqci_pkg::NUM_COORDS-1:0][COORD_BITS-1:0] rem_in,
	input  wire  [lqci_pkg::NUM_COORDS-1:0][MAX_DEPTH-1:0]  quo_in,
	output lqci_pkg::beat_ctl_t                             ctl_out,
	output logic [lqci_pkg::NUM_COORDS-1:0][COORD_BITS-1:0] rem_out,
	output logic [lqci_pkg::NUM_COORDS-1:0][MAX_DEPTH-1:0]  quo_out
);

	import lqci_pkg::*;

	localparam int W = COORD_BITS + MAX_DEPTH;

	logic [W-1:0]                           ext_rem [NUM_COORDS];
	logic [W-1:0]                           ext_div [NUM_COORDS];
	logic [W-1:0]                           ext_sub [NUM_COORDS];
	logic [NUM_COORDS-1:0][COORD_BITS-1:0]  rem_next;
	logic [NUM_COORDS-1:0][MAX_DEPTH-1:0]   quo_next;
	beat_ctl_t                              ctl_s1;
	logic [NUM_COORDS-1:0][COORD_BITS-1:0]  rem_s1;
	logic [NUM_COORDS-1:0][MAX_DEPTH-1:0]   quo_s1;

	// one restoring step per coordinate, x sizes on even lanes
	always_comb begin
		for (int j = 0; j < NUM_COORDS; j++) begin
			ext_rem[j] = {{MAX_DEPTH{1'b0}}, rem_in[j]};
			if (j % 2 == 0) begin
				ext_div[j] = {{MAX_DEPTH{1'b0}}, size_x} << STEP;
			end else begin
				ext_div[j] = {{MAX_DEPTH{1'b0}}, size_y} << STEP;
			end
			ext_sub[j] = ext_rem[j] - ext_div[j];
			quo_next[j] = quo_in[j];
			if (ext_rem[j] >= ext_div[j]) begin
				rem_next[j] = ext_sub[j][COORD_BITS-1:0];
				quo_next[j][STEP] = 1'b1;
			end else begin
				rem_next[j] = rem_in[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_s1 <= rem_next;
		quo_s1 <= quo_next;
	end

	assign ctl_out = ctl_s1;
	assign rem_out = rem_s1;
	assign quo_out = quo_s1;

endmodule

`default_nettype wire

/* hw/rtl/lqci_index.sv */
`default_nettype none

module lqci_index #(
	parameter int MAX_DEPTH = 8
) (
	input  wire                                            clk,
	input  wire                                            arst_n,
	input  wire  [lqci_pkg::LEVEL_W-1:0]                   lv,
	input  lqci_pkg::beat_ctl_t                            ctl_in,
	input  wire  [lqci_pkg::NUM_COORDS-1:0][MAX_DEPTH-1:0] quo_in,
	output logic                                           done,
	output logic                                           valid_res,
	output logic [lqci_pkg::INDEX_W-1:0]                   cell_index,
	output logic [lqci_pkg::LEVEL_W-1:0]                   cell_depth
);

	import lqci_pkg::*;

	localparam int CODE_W = 2 * MAX_DEPTH;

	logic [CODE_W-1:0]         c1;
	logic [CODE_W-1:0]         c2;
	logic [CODE_W-1:0]         diff;
	logic [CODE_W-1:0]         offset;
	logic [CODE_W-1:0]         idx;
	logic [CODE_W+INDEX_W-1:0] idx_wide;
	logic [LEVEL_W-1:0]        shift;
	logic [LEVEL_W-1:0]        depth;
	logic                      ok;
	logic                      done_q;
	logic                      valid_res_q;
	logic [INDEX_W-1:0]        cell_index_q;
	logic [LEVEL_W-1:0]        cell_depth_q;

	always_comb begin
		c1 = '0;
		c2 = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			c1[2*i]   = quo_in[0][i];
			c1[2*i+1] = quo_in[1][i];
			c2[2*i]   = quo_in[2][i];
			c2[2*i+1] = quo_in[3][i];
		end
		diff = c1 ^ c2;
		// highest differing pair below the level count
		shift = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if (LEVEL_W'(i) < lv && diff[2*i +: 2] != 2'b00) begin
				shift = LEVEL_W'(i + 1);
			end
		end
		depth = lv - shift;
		// (4^depth - 1) / 3 is depth ones on even bits
		offset = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if (LEVEL_W'(i) < depth) begin
				offset[2*i] = 1'b1;
			end
		end
		idx      = (c1 >> {shift, 1'b0}) + offset;
		idx_wide = {{INDEX_W{1'b0}}, idx};
		ok       = !ctl_in.outside && shift != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		valid_res_q  <= ok;
		cell_index_q <= ok ? idx_wide[INDEX_W-1:0] : '0;
		cell_depth_q <= ok ? depth : '0;
	end

	assign done       = done_q;
	assign valid_res  = valid_res_q;
	assign cell_index = cell_index_q;
	assign cell_depth = cell_depth_q;

endmodule

`default_nettype wire

/* tb/sv/linear_quadtree_cell_index_checker.sv */
`default_nettype none

module linear_quadtree_cell_index_checker #(
	parameter int MAX_DEPTH  = 8,
	parameter int COORD_BITS = 24
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire                              busy,
	input  wire [COORD_BITS-1:0]             left_x,
	input  wire [COORD_BITS-1:0]             low_y,
	input  wire [COORD_BITS-1:0]             right_x,
	input  wire [COORD_BITS-1:0]             high_y,
	input  wire                              done,
	input  wire                              valid_res,
	input  wire [lqci_pkg::INDEX_W-1:0]      cell_index,
	input  wire [lqci_pkg::LEVEL_W-1:0]      cell_depth,
	input  wire                              wr_en,
	input  lqci_pkg::cfg_addr_t              wr_index,
	input  wire [lqci_pkg::CFG_DATA_W-1:0]   wr_data,
	output int                               err_count,
	output int                               pending,
	output int                               valid_count,
	output int                               rejected_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import lqci_pkg::*;

	typedef struct packed {
		logic               valid;
		logic [INDEX_W-1:0] index;
		logic [LEVEL_W-1:0] depth;
	} cell_result_t;

	logic [LEVEL_W-1:0]    levels_q;
	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;
	cell_result_t          cell_results_q[$];
	cell_result_t          want;
	int                    errors = 0;
	int                    n_pending = 0;
	int                    n_valid = 0;
	int                    n_rejected = 0;

	assign err_count      = errors;
	assign pending        = n_pending;
	assign valid_count    = n_valid;
	assign rejected_count = n_rejected;

	function automatic logic [31:0] grid_of(logic [COORD_BITS-1:0] pos,
			logic [CFG_DATA_W-1:0] size);
		if (size == '0)
			return 32'hffff_ffff;
		return 32'(pos) / 32'(size);
	endfunction

	function automatic logic [31:0] interleave(logic [31:0] g);
		logic [31:0] r;
		r = '0;
		for (int i = 0; i < 16; i++)
			r[2*i] = g[i];
		return r;
	endfunction

	function automatic cell_result_t enclosing_cell(
			logic [COORD_BITS-1:0] lx, logic [COORD_BITS-1:0] ly,
			logic [COORD_BITS-1:0] rx, logic [COORD_BITS-1:0] hy,
			logic [LEVEL_W-1:0] levels, logic [CFG_DATA_W-1:0] w,
			logic [CFG_DATA_W-1:0] h);
		int unsigned     lv, shift, depth;
		logic [31:0]     gx1, gy1, gx2, gy2, lim, c1, c2, diff;
		longint unsigned offset, idx;
		cell_result_t    r;
		r = '0;
		lv = (levels > MAX_DEPTH) ? MAX_DEPTH : levels;
		gx1 = grid_of(lx, w);
		gy1 = grid_of(ly, h);
		gx2 = grid_of(rx, w);
		gy2 = grid_of(hy, h);
		lim = 32'd1 << lv;
		if (gx1 >= lim || gy1 >= lim || gx2 >= lim || gy2 >= lim)
			return r;
		c1 = interleave(gx1) | (interleave(gy1) << 1);
		c2 = interleave(gx2) | (interleave(gy2) << 1);
		diff = c1 ^ c2;
		shift = 0;
		for (int i = 0; i < lv; i++)
			if (diff[2*i +: 2] != 2'b00)
				shift = i + 1;
		// both corners in one finest cell
		if (shift == 0)
			return r;
		depth = lv - shift;
		offset = ((64'd1 << (2 * depth)) - 1) / 3;
		idx = 64'(c1 >> (2 * shift)) + offset;
		r.valid = 1'b1;
		r.index = idx[INDEX_W-1:0];
		r.depth = depth[LEVEL_W-1:0];
		return r;
	endfunction

	task automatic report_error(string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q = LEVELS_RESET;
			width_q  = CELL_SIZE_RESET;
			height_q = CELL_SIZE_RESET;
			cell_results_q.delete();
			n_pending = 0;
		end else begin
			if (done) begin
				if (cell_results_q.size() == 0) begin
					report_error("result beat with no box outstanding");
				end else begin
					want = cell_results_q.pop_front();
					if (valid_res !== want.valid)
						report_error($sformatf("valid_res got %b expected %b",
							valid_res, want.valid));
					if (cell_index !== want.index)
						report_error($sformatf("cell_index got %0d expected %0d",
							cell_index, want.index));
					if (cell_depth !== want.depth)
						report_error($sformatf("cell_depth got %0d expected %0d",
							cell_depth, want.depth));
					if (want.valid)
						n_valid++;
					else
						n_rejected++;
				end
			end
			if (start && !busy)
				cell_results_q.push_back(enclosing_cell(left_x, low_y, right_x, high_y,
					levels_q, width_q, height_q));
			if (wr_en) begin
				case (wr_index)
					REG_TREE_LEVELS: levels_q = wr_data[LEVEL_W-1:0];
					REG_CELL_WIDTH:  width_q  = wr_data;
					REG_CELL_HEIGHT: height_q = wr_data;
					default: ;
				endcase
			end
			n_pending = cell_results_q.size();
		end
	end

endmodule

`default_nettype wire

/* tb/sv/linear_quadtree_cell_index_tb.sv */
`default_nettype none

module linear_quadtree_cell_index_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lqci_pkg::*;

	localparam int MAX_DEPTH  = 8;
	localparam int COORD_BITS = 24;
	localparam int LATENCY    = MAX_DEPTH + 2;
	localparam cfg_addr_t REG_UNUSED = 2'd3;
	localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [COORD_BITS-1:0] left_x = '0;
	logic [COORD_BITS-1:0] low_y = '0;
	logic [COORD_BITS-1:0] right_x = '0;
	logic [COORD_BITS-1:0] high_y = '0;
	logic                  done;
	logic                  valid_res;
	logic [INDEX_W-1:0]    cell_index;
	logic [LEVEL_W-1:0]    cell_depth;
	logic                  wr_en = 1'b0;
	cfg_addr_t             wr_index = REG_TREE_LEVELS;
	logic [CFG_DATA_W-1:0] wr_data = '0;

	int err_count, pending, valid_count, rejected_count;
	int boxes_sent = 0;
	int settings_used = 1;

	logic [LEVEL_W-1:0]    cur_levels = LEVELS_RESET;
	logic [CFG_DATA_W-1:0] cur_width  = CELL_SIZE_RESET;
	logic [CFG_DATA_W-1:0] cur_height = CELL_SIZE_RESET;

	always #5 clk = ~clk;

	linear_quadtree_cell_index #(
		.MAX_DEPTH (MAX_DEPTH),
		.COORD_BITS(COORD_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.left_x    (left_x),
		.low_y     (low_y),
		.right_x   (right_x),
		.high_y    (high_y),
		.done      (done),
		.valid_res (valid_res),
		.cell_index(cell_index),
		.cell_depth(cell_depth),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	linear_quadtree_cell_index_checker #(
		.MAX_DEPTH (MAX_DEPTH),
		.COORD_BITS(COORD_BITS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.left_x        (left_x),
		.low_y         (low_y),
		.right_x       (right_x),
		.high_y        (high_y),
		.done          (done),
		.valid_res     (valid_res),
		.cell_index    (cell_index),
		.cell_depth    (cell_depth),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.err_count     (err_count),
		.pending       (pending),
		.valid_count   (valid_count),
		.rejected_count(rejected_count)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// coordinate somewhere inside grid cell g
	function automatic logic [COORD_BITS-1:0] coord_in(longint unsigned g,
			logic [CFG_DATA_W-1:0] size);
		longint unsigned v;
		if (size == '0)
			return COORD_BITS'($urandom);
		v = g * size + $urandom_range(0, size - 1);
		if (v > COORD_MAX)
			v = COORD_MAX;
		return v[COORD_BITS-1:0];
	endfunction

	task automatic send_box(logic [COORD_BITS-1:0] lx, logic [COORD_BITS-1:0] ly,
			logic [COORD_BITS-1:0] rx, logic [COORD_BITS-1:0] hy);
		left_x  <= lx;
		low_y   <= ly;
		right_x <= rx;
		high_y  <= hy;
		start   <= 1'b1;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		boxes_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_config(logic [LEVEL_W-1:0] lv, logic [CFG_DATA_W-1:0] w,
			logic [CFG_DATA_W-1:0] h, bit junk);
		logic [CFG_DATA_W-1:0] lv_word;
		lv_word = junk ? {20'($urandom), lv} : CFG_DATA_W'(lv);
		wr_en    <= 1'b1;
		wr_index <= REG_TREE_LEVELS;
		wr_data  <= lv_word;
		@(posedge clk);
		wr_index <= REG_CELL_WIDTH;
		wr_data  <= w;
		@(posedge clk);
		wr_index <= REG_CELL_HEIGHT;
		wr_data  <= h;
		@(posedge clk);
		if (junk) begin
			wr_index <= REG_UNUSED;
			wr_data  <= CFG_DATA_W'($urandom);
			@(posedge clk);
		end
		wr_en <= 1'b0;
		@(posedge clk);
		cur_levels = lv;
		cur_width  = w;
		cur_height = h;
		settings_used++;
	endtask

	task automatic make_box(output logic [COORD_BITS-1:0] lx, output logic [COORD_BITS-1:0] ly,
			output logic [COORD_BITS-1:0] rx, output logic [COORD_BITS-1:0] hy);
		int unsigned     lv, s, kind;
		longint unsigned gx1, gy1, gx2, gy2, span, tmp;
		lv = (cur_levels > MAX_DEPTH) ? MAX_DEPTH : cur_levels;
		kind = $urandom_range(0, 99);
		gx1 = $urandom_range(0, (1 << lv) - 1);
		gy1 = $urandom_range(0, (1 << lv) - 1);
		if (kind < 70) begin
			// corners sharing an aligned block of random size
			s = $urandom_range(0, lv);
			span = 1 << s;
			gx2 = (gx1 & ~(span - 1)) + $urandom_range(0, span - 1);
			gy2 = (gy1 & ~(span - 1)) + $urandom_range(0, span - 1);
			if ($urandom_range(0, 99) < 15) begin
				tmp = gx1; gx1 = gx2; gx2 = tmp;
				tmp = gy1; gy1 = gy2; gy2 = tmp;
			end
		end else if (kind < 85) begin
			// one coordinate on or just past the grid edge
			gx2 = $urandom_range(0, (1 << lv) - 1);
			gy2 = $urandom_range(0, (1 << lv) - 1);
			tmp = $urandom_range(0, 1) ? (1 << lv) + $urandom_range(0, 3) : (1 << lv) - 1;
			case ($urandom_range(0, 3))
				0: gx1 = tmp;
				1: gy1 = tmp;
				2: gx2 = tmp;
				default: gy2 = tmp;
			endcase
		end else begin
			lx = COORD_BITS'($urandom);
			ly = COORD_BITS'($urandom);
			rx = COORD_BITS'($urandom);
			hy = COORD_BITS'($urandom);
			return;
		end
		lx = coord_in(gx1, cur_width);
		ly = coord_in(gy1, cur_height);
		rx = coord_in(gx2, cur_width);
		hy = coord_in(gy2, cur_height);
	endtask

	task automatic run_boxes(int count, bit pause_mid);
		logic [COORD_BITS-1:0] lx, ly, rx, hy;
		bit no_gaps;
		int gap;
		no_gaps = ($urandom_range(0, 3) == 0);
		for (int n = 0; n < count; n++) begin
			make_box(lx, ly, rx, hy);
			send_box(lx, ly, rx, hy);
			gap = no_gaps ? 0 : gap_len();
			if (pause_mid && n == count / 2)
				gap = -1;
			if (gap != 0 || n == count - 1)
				start <= 1'b0;
			if (gap < 0)
				wait_idle();
			else
				repeat (gap) @(posedge clk);
		end
		wait_idle();
	endtask

	task automatic directed_box(logic [COORD_BITS-1:0] lx, logic [COORD_BITS-1:0] ly,
			logic [COORD_BITS-1:0] rx, logic [COORD_BITS-1:0] hy);
		int gap;
		send_box(lx, ly, rx, hy);
		gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		logic [LEVEL_W-1:0]    lv;
		logic [CFG_DATA_W-1:0] w, h;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 256 per cell, 8 levels
		directed_box(24'h000000, 24'h000000, 24'h000000, 24'h000000);
		directed_box(24'h000000, 24'h000000, 24'h00ffff, 24'h00ffff);
		directed_box(24'h000000, 24'h000000, COORD_MAX, COORD_MAX);
		directed_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		directed_box(24'h000000, 24'h000000, 24'h010000, 24'h000000);
		directed_box(24'h000000, 24'h000000, 24'h000000, 24'h010000);
		directed_box(24'h000000, 24'h000000, 24'h000100, 24'h000000);
		directed_box(24'h000000, 24'h000000, 24'h000000, 24'h000100);
		directed_box(24'h007f00, 24'h007f00, 24'h008000, 24'h008000);
		directed_box(24'h00ffff, 24'h00ffff, 24'h000000, 24'h000000);
		directed_box(24'h00ff00, 24'h00ff00, 24'h00ffff, 24'h00ffff);
		directed_box(24'h001234, 24'h005678, 24'h001300, 24'h005700);
		directed_box(24'h008000, 24'h000000, 24'h00ffff, 24'h007fff);
		directed_box(24'h00c000, 24'h00c000, 24'h00ffff, 24'h00ffff);
		directed_box(24'haaaaaa, 24'h555555, 24'h555555, 24'haaaaaa);
		directed_box(24'h0000ff, 24'h00ff00, 24'h00ff00, 24'h0000ff);
		directed_box(24'h00fe00, 24'h00fe00, 24'h00ff00, 24'h00ff00);
		directed_box(24'h000000, 24'h00ffff, 24'h00ffff, 24'h000000);
		start <= 1'b0;
		wait_idle();

		write_config(4'd1, 24'd256, 24'd256, 1'b0);
		run_boxes(60, 1'b0);
		write_config(4'd0, 24'd256, 24'd256, 1'b0);
		run_boxes(40, 1'b0);
		write_config(4'd15, 24'd256, 24'd256, 1'b1);
		run_boxes(60, 1'b0);
		write_config(4'd8, 24'd1, 24'd1, 1'b0);
		run_boxes(60, 1'b0);
		write_config(4'd8, 24'hffffff, 24'hffffff, 1'b0);
		run_boxes(60, 1'b0);
		write_config(4'd4, 24'd0, 24'd256, 1'b0);
		run_boxes(40, 1'b0);
		write_config(4'd4, 24'd256, 24'd0, 1'b1);
		run_boxes(40, 1'b0);

		for (int p = 0; p < 10; p++) begin
			lv = LEVEL_W'(($urandom_range(0, 99) < 80) ? $urandom_range(1, 8)
				: $urandom_range(0, 15));
			w = CFG_DATA_W'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 512)
				: $urandom_range(1, 24'hffffff >> ((lv > MAX_DEPTH) ? MAX_DEPTH : lv)));
			h = ($urandom_range(0, 2) == 0) ? w : CFG_DATA_W'($urandom_range(1, 4096));
			write_config(lv, w, h, 1'($urandom_range(0, 1)));
			run_boxes(125, p % 2 == 0);
		end

		$display("Summary: %0d boxes over %0d register settings", boxes_sent, settings_used);
		$display("Summary: %0d in-grid cell indices, %0d rejected boxes",
			valid_count, rejected_count);
		if (err_count == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("timeout with %0d results outstanding", pending);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
